@@ hw/rtl/ghsp_pkg.sv @@
// Shared types and constants for the generational handle slot pool.
// Used by every module of the block. No dependencies.
`timescale 1ns / 1ps

package ghsp_pkg;

  localparam int unsigned SLOTS   = 1024;
  localparam int unsigned IDX_W   = $clog2(SLOTS);
  localparam int unsigned HND_W   = IDX_W + 1;
  localparam int unsigned PENDING = 64;
  localparam int unsigned PQ_W    = $clog2(PENDING);
  localparam int unsigned PCNT_W  = PQ_W + 1;
  localparam int unsigned GEN_W   = 16;
  localparam int unsigned PAY_W   = 32;
  localparam int unsigned CNT_W   = 7;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_LOOKUP  = 2'd1,
    CMD_DESTROY = 2'd2,
    CMD_FLUSH   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_STALE   = 3'd2,
    ST_DEAD    = 3'd3,
    ST_FULL    = 3'd4,
    ST_RANGE   = 3'd5,
    ST_QFULL   = 3'd6
  } status_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [HND_W-1:0]  slot_index;
    logic [GEN_W-1:0]  handle_generation;
    logic [PAY_W-1:0]  payload;
  } cmd_t;

  typedef struct packed {
    status_e           status;
    logic [IDX_W-1:0]  out_index;
    logic [GEN_W-1:0]  out_generation;
    logic [PAY_W-1:0]  payload_out;
    logic [CNT_W-1:0]  freed_count;
  } rsp_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctl_t;

  typedef struct packed {
    logic push;
    logic rd;
    logic clear;
  } pq_ctl_t;

endpackage

@@ hw/rtl/ghsp_free_stack.sv @@
// LIFO of freed slot indexes held in a synchronous memory, with its depth counter.
// Depends on ghsp_pkg.
`timescale 1ns / 1ps

module ghsp_free_stack import ghsp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  stk_ctl_t         ctl_i,
  input  logic [IDX_W-1:0] push_data_i,
  output logic [IDX_W-1:0] pop_data_o,
  output logic             empty_o,
  output logic             full_o
);

  logic [IDX_W-1:0] mem [SLOTS];
  logic [HND_W-1:0] depth_q, depth_d;
  logic [HND_W-1:0] top_idx;
  logic [IDX_W-1:0] pop_data_q;
  logic             do_push, do_pop;

  assign empty_o = (depth_q == '0);
  assign full_o  = (depth_q == HND_W'(SLOTS));
  assign top_idx = depth_q - 1'b1;
  assign do_push = ctl_i.push && !full_o;
  assign do_pop  = ctl_i.pop && !empty_o;

  always_comb begin
    depth_d = depth_q;
    if (do_push) begin
      depth_d = depth_q + 1'b1;
    end else if (do_pop) begin
      depth_d = top_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
    end else begin
      depth_q <= depth_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[depth_q[IDX_W-1:0]] <= push_data_i;
    end
    if (do_pop) begin
      pop_data_q <= mem[top_idx[IDX_W-1:0]];
    end
  end

  assign pop_data_o = pop_data_q;

endmodule

@@ hw/rtl/ghsp_pend_queue.sv @@
// Pending-delete list in a synchronous memory: append, indexed read, clear.
// Depends on ghsp_pkg.
`timescale 1ns / 1ps

module ghsp_pend_queue import ghsp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pq_ctl_t           ctl_i,
  input  logic [IDX_W-1:0]  push_data_i,
  input  logic [PQ_W-1:0]   rd_addr_i,
  output logic [IDX_W-1:0]  rd_data_o,
  output logic [PCNT_W-1:0] count_o,
  output logic              full_o
);

  logic [IDX_W-1:0]  mem [PENDING];
  logic [PCNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0]  rd_data_q;
  logic              do_push;

  assign full_o  = (count_q == PCNT_W'(PENDING));
  assign do_push = ctl_i.push && !full_o;

  always_comb begin
    count_d = count_q;
    if (ctl_i.clear) begin
      count_d = '0;
    end else if (do_push) begin
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[count_q[PQ_W-1:0]] <= push_data_i;
    end
    if (ctl_i.rd) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign count_o   = count_q;

endmodule

@@ hw/rtl/generational_handle_slot_pool.sv @@
// Top level of the generational handle slot pool: command sequencer and slot table.
// Depends on ghsp_pkg, ghsp_free_stack and ghsp_pend_queue.
//
// Usage: drive cmd_i and raise start; the command is taken at a rising edge
// where start is high and busy is low. Each command yields one result beat on
// rsp_o, marked by rsp_valid_o for exactly one cycle; the receiver cannot
// stall it and must take it in that cycle.
// Steps from accept to result:
//   allocate, table full: none; growing the table: slot write
//   allocate reusing a freed slot: stack read, slot read, write
//   lookup, destroy: slot read, check; none on a range or invalid-handle error
//   flush: queue read, slot read-modify-write per queued entry; none if empty
// The slot table is one single-port-read memory that the commands read and
// write in turn, so one command is in flight at a time and busy stays high
// until its result is out.
// Reset empties the table (fill count to zero), the free stack and the
// pending-delete list; no clearing pass is needed and a command may be
// given in the first cycle after reset.
`timescale 1ns / 1ps

module generational_handle_slot_pool import ghsp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  cmd_t cmd_i,
  output logic rsp_valid_o,
  output rsp_t rsp_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_AL_POP,
    S_AL_WR,
    S_LK,
    S_DS,
    S_FL_Q,
    S_FL_S
  } state_e;

  typedef struct packed {
    logic             live;
    logic [GEN_W-1:0] gen;
    logic [PAY_W-1:0] data;
  } slot_t;

  slot_t slot_mem [SLOTS];
  slot_t slot_rdata_q, slot_wdata;
  logic             slot_rd, slot_we;
  logic [IDX_W-1:0] slot_raddr;

  state_e            state_q, state_d;
  cmd_t              cmd_q, cmd_d;
  logic [HND_W-1:0]  hw_q, hw_d;
  logic [IDX_W-1:0]  slot_q, slot_d;
  logic              fresh_q, fresh_d;
  logic [PCNT_W-1:0] fl_idx_q, fl_idx_d, fl_next;
  logic [CNT_W-1:0]  freed_q, freed_d;
  rsp_t              rsp_q, rsp_d;
  logic              rsp_valid_q, rsp_valid_d;

  stk_ctl_t          stk_ctl;
  logic [IDX_W-1:0]  stk_pop_data;
  logic              stk_empty, stk_full;

  pq_ctl_t           pq_ctl;
  logic [PQ_W-1:0]   pq_rd_addr;
  logic [IDX_W-1:0]  pq_rd_data;
  logic [PCNT_W-1:0] pq_count;
  logic              pq_full;

  logic              accept;
  logic [GEN_W-1:0]  gen_cur;

  ghsp_free_stack u_stack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (stk_ctl),
    .push_data_i (slot_q),
    .pop_data_o  (stk_pop_data),
    .empty_o     (stk_empty),
    .full_o      (stk_full)
  );

  ghsp_pend_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (pq_ctl),
    .push_data_i (cmd_q.slot_index[IDX_W-1:0]),
    .rd_addr_i   (pq_rd_addr),
    .rd_data_o   (pq_rd_data),
    .count_o     (pq_count),
    .full_o      (pq_full)
  );

  assign busy    = (state_q != S_IDLE);
  assign accept  = start && !busy;
  assign fl_next = fl_idx_q + 1'b1;
  // never-grown slots read as dead with generation zero
  assign gen_cur = fresh_q ? '0 : slot_rdata_q.gen;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    hw_d        = hw_q;
    slot_d      = slot_q;
    fresh_d     = fresh_q;
    fl_idx_d    = fl_idx_q;
    freed_d     = freed_q;
    rsp_d       = '0;
    rsp_d.status = ST_OK;
    rsp_valid_d = 1'b0;
    slot_rd     = 1'b0;
    slot_raddr  = cmd_i.slot_index[IDX_W-1:0];
    slot_we     = 1'b0;
    slot_wdata  = slot_rdata_q;
    stk_ctl     = '0;
    pq_ctl      = '0;
    pq_rd_addr  = fl_next[PQ_W-1:0];

    case (state_q)
      S_IDLE: begin
        pq_rd_addr = '0;
        if (accept) begin
          cmd_d = cmd_i;
          case (cmd_i.cmd)
            CMD_ALLOC: begin
              if (!stk_empty) begin
                stk_ctl.pop = 1'b1;
                state_d     = S_AL_POP;
              end else if (hw_q < HND_W'(SLOTS)) begin
                slot_d  = hw_q[IDX_W-1:0];
                fresh_d = 1'b1;
                hw_d    = hw_q + 1'b1;
                state_d = S_AL_WR;
              end else begin
                rsp_d.status = ST_FULL;
                rsp_valid_d  = 1'b1;
              end
            end
            CMD_LOOKUP: begin
              if (cmd_i.slot_index >= hw_q) begin
                rsp_d.status = ST_RANGE;
                rsp_valid_d  = 1'b1;
              end else begin
                slot_rd = 1'b1;
                state_d = S_LK;
              end
            end
            CMD_DESTROY: begin
              if (cmd_i.slot_index == HND_W'(SLOTS)) begin
                rsp_d.status = ST_INVALID;
                rsp_valid_d  = 1'b1;
              end else if (cmd_i.slot_index >= hw_q) begin
                rsp_d.status = ST_RANGE;
                rsp_valid_d  = 1'b1;
              end else begin
                slot_rd = 1'b1;
                state_d = S_DS;
              end
            end
            default: begin
              if (pq_count == '0) begin
                rsp_valid_d = 1'b1;
              end else begin
                pq_ctl.rd = 1'b1;
                fl_idx_d  = '0;
                freed_d   = '0;
                state_d   = S_FL_Q;
              end
            end
          endcase
        end
      end
      S_AL_POP: begin
        slot_rd    = 1'b1;
        slot_raddr = stk_pop_data;
        slot_d     = stk_pop_data;
        fresh_d    = 1'b0;
        state_d    = S_AL_WR;
      end
      S_AL_WR: begin
        slot_we              = 1'b1;
        slot_wdata.live      = 1'b1;
        slot_wdata.gen       = gen_cur;
        slot_wdata.data      = cmd_q.payload;
        rsp_d.out_index      = slot_q;
        rsp_d.out_generation = gen_cur;
        rsp_valid_d          = 1'b1;
        state_d              = S_IDLE;
      end
      S_LK: begin
        if (!slot_rdata_q.live) begin
          rsp_d.status = ST_DEAD;
        end else if (slot_rdata_q.gen != cmd_q.handle_generation) begin
          rsp_d.status = ST_STALE;
        end else begin
          rsp_d.payload_out = slot_rdata_q.data;
        end
        rsp_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      S_DS: begin
        if (slot_rdata_q.gen != cmd_q.handle_generation) begin
          rsp_d.status = ST_STALE;
        end else if (pq_full) begin
          rsp_d.status = ST_QFULL;
        end else begin
          pq_ctl.push = 1'b1;
        end
        rsp_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      S_FL_Q: begin
        slot_rd    = 1'b1;
        slot_raddr = pq_rd_data;
        slot_d     = pq_rd_data;
        state_d    = S_FL_S;
      end
      S_FL_S: begin
        if (slot_rdata_q.live) begin
          slot_we         = 1'b1;
          slot_wdata.live = 1'b0;
          slot_wdata.gen  = slot_rdata_q.gen + 1'b1;
          stk_ctl.push    = !stk_full;
          freed_d         = freed_q + 1'b1;
        end
        fl_idx_d = fl_next;
        if (fl_next == pq_count) begin
          pq_ctl.clear      = 1'b1;
          rsp_d.freed_count = freed_d;
          rsp_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end else begin
          pq_ctl.rd = 1'b1;
          state_d   = S_FL_Q;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      hw_q        <= '0;
      rsp_valid_q <= 1'b0;
      rsp_q       <= '0;
    end else begin
      state_q     <= state_d;
      hw_q        <= hw_d;
      rsp_valid_q <= rsp_valid_d;
      rsp_q       <= rsp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    slot_q   <= slot_d;
    fresh_q  <= fresh_d;
    fl_idx_q <= fl_idx_d;
    freed_q  <= freed_d;
  end

  always_ff @(posedge clk_i) begin
    if (slot_rd) begin
      slot_rdata_q <= slot_mem[slot_raddr];
    end
    if (slot_we) begin
      slot_mem[slot_q] <= slot_wdata;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

@@ hw/rtl/ghsp_checker.sv @@
// Port-level checks for the generational handle slot pool, bound to the top level.
// Depends on ghsp_pkg and generational_handle_slot_pool.
`timescale 1ns / 1ps

module ghsp_checker import ghsp_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic rsp_valid_o,
  input rsp_t rsp_o
);

  // a result beat only ends a command, never while one is still running
  a_rsp_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !busy)
    else $error("result beat while busy");

  // no beat appears without an accepted or running command
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy && !start) |=> !rsp_valid_o)
    else $error("result beat without a command");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.status != ST_OK) |->
      (rsp_o.out_index == '0 && rsp_o.out_generation == '0 &&
       rsp_o.payload_out == '0 && rsp_o.freed_count == '0))
    else $error("error result carries data");

  a_freed_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> (rsp_o.freed_count <= CNT_W'(PENDING)))
    else $error("freed count beyond pending capacity");

endmodule

bind generational_handle_slot_pool ghsp_checker u_ghsp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .rsp_valid_o (rsp_valid_o),
  .rsp_o       (rsp_o)
);

@@ bench/ghsp_tb_pkg.sv @@
// Scoreboard for the generational handle slot pool bench: keeps a shadow copy of
// the slot table, free stack and pending-delete list, and checks each result beat.
// Depends on ghsp_pkg.
`timescale 1ns / 1ps

package ghsp_tb_pkg;
  import ghsp_pkg::*;

  class slot_pool_shadow;
    bit                  live      [SLOTS];
    logic [GEN_W-1:0]    gens      [SLOTS];
    logic [PAY_W-1:0]    pays      [SLOTS];
    int unsigned         free_stk  [SLOTS];
    int unsigned         pend      [PENDING];
    int unsigned         free_cnt;
    int unsigned         fill_cnt;
    int unsigned         pend_cnt;
    rsp_t                due_rsp_q [$];
    int unsigned         n_cmds;
    int unsigned         n_rsps;
    int unsigned         errors;
    int unsigned         status_seen [8];

    function new();
      foreach (live[i]) begin
        live[i] = 1'b0;
        gens[i] = '0;
        pays[i] = '0;
        free_stk[i] = 0;
      end
      foreach (pend[i]) pend[i] = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      free_cnt = 0;
      fill_cnt = 0;
      pend_cnt = 0;
      n_cmds   = 0;
      n_rsps   = 0;
      errors   = 0;
    endfunction

    // Advance the shadow state by one accepted command and queue its answer.
    function void apply_cmd(cmd_t c);
      rsp_t        r;
      int unsigned s;
      int unsigned idx;
      r = '0;
      r.status = ST_OK;
      idx = c.slot_index;
      case (c.cmd)
        CMD_ALLOC: begin
          if (free_cnt > 0) begin
            free_cnt--;
            s = free_stk[free_cnt];
          end else if (fill_cnt < SLOTS) begin
            s = fill_cnt;
            fill_cnt++;
          end else begin
            r.status = ST_FULL;
          end
          if (r.status == ST_OK) begin
            live[s] = 1'b1;
            pays[s] = c.payload;
            r.out_index = IDX_W'(s);
            r.out_generation = gens[s];
          end
        end
        CMD_LOOKUP: begin
          if (idx >= fill_cnt) r.status = ST_RANGE;
          else if (!live[idx]) r.status = ST_DEAD;
          else if (gens[idx] != c.handle_generation) r.status = ST_STALE;
          else r.payload_out = pays[idx];
        end
        CMD_DESTROY: begin
          if (idx == SLOTS) r.status = ST_INVALID;
          else if (idx >= fill_cnt) r.status = ST_RANGE;
          else if (gens[idx] != c.handle_generation) r.status = ST_STALE;
          else if (pend_cnt >= PENDING) r.status = ST_QFULL;
          else begin
            pend[pend_cnt] = idx;
            pend_cnt++;
          end
        end
        default: begin
          for (int unsigned i = 0; i < pend_cnt; i++) begin
            s = pend[i];
            if (live[s]) begin
              live[s] = 1'b0;
              gens[s] = gens[s] + 1'b1;
              if (free_cnt < SLOTS) begin
                free_stk[free_cnt] = s;
                free_cnt++;
              end
              r.freed_count = r.freed_count + 1'b1;
            end
          end
          pend_cnt = 0;
        end
      endcase
      due_rsp_q.insert(due_rsp_q.size(), r);
      n_cmds++;
    endfunction

    function void check_rsp(rsp_t a);
      rsp_t e;
      n_rsps++;
      if (due_rsp_q.size() == 0) begin
        $error("result beat with nothing outstanding, status %0d", a.status);
        errors++;
        return;
      end
      e = due_rsp_q.pop_front();
      status_seen[e.status]++;
      if (a.status !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, a.status);
        errors++;
      end
      if (a.out_index !== e.out_index) begin
        $error("out_index: expected %0d, actual %0d", e.out_index, a.out_index);
        errors++;
      end
      if (a.out_generation !== e.out_generation) begin
        $error("out_generation: expected %0d, actual %0d",
               e.out_generation, a.out_generation);
        errors++;
      end
      if (a.payload_out !== e.payload_out) begin
        $error("payload_out: expected %h, actual %h", e.payload_out, a.payload_out);
        errors++;
      end
      if (a.freed_count !== e.freed_count) begin
        $error("freed_count: expected %0d, actual %0d", e.freed_count, a.freed_count);
        errors++;
      end
    endfunction
  endclass

endpackage

@@ bench/tb_top.sv @@
// Top-level bench for generational_handle_slot_pool: directed handle cases, then
// weighted random command phases with sender gaps. Depends on ghsp_pkg, ghsp_tb_pkg.
`timescale 1ns / 1ps

module tb_top;
  import ghsp_pkg::*;
  import ghsp_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  cmd_t cmd_i;
  logic rsp_valid_o;
  rsp_t rsp_o;

  slot_pool_shadow sb;
  int unsigned     idle_pct;
  int unsigned     cycles;

  generational_handle_slot_pool u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o) sb.check_rsp(rsp_o);
  end

  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic cmd_t mk_cmd(cmd_e op, int unsigned idx, int unsigned gen,
                                  logic [PAY_W-1:0] pay);
    cmd_t c;
    c.cmd = op;
    c.slot_index = HND_W'(idx);
    c.handle_generation = GEN_W'(gen);
    c.payload = pay;
    return c;
  endfunction

  // Weighted command mix; flush takes what is left of 100.
  // Handles are mostly well formed, drawn from the shadow table.
  function automatic cmd_t rand_cmd(int unsigned w_alloc, int unsigned w_lookup,
                                    int unsigned w_destroy);
    cmd_t        c;
    int unsigned roll;
    int unsigned pick;
    int unsigned hw;
    roll = $urandom_range(99);
    pick = $urandom_range(99);
    hw = sb.fill_cnt;
    c.slot_index = HND_W'($urandom_range(2047));
    c.handle_generation = GEN_W'($urandom_range(16'hFFFF));
    c.payload = $urandom;
    if (roll < w_alloc) c.cmd = CMD_ALLOC;
    else if (roll < w_alloc + w_lookup) c.cmd = CMD_LOOKUP;
    else if (roll < w_alloc + w_lookup + w_destroy) c.cmd = CMD_DESTROY;
    else c.cmd = CMD_FLUSH;
    if (c.cmd == CMD_LOOKUP || c.cmd == CMD_DESTROY) begin
      if (pick < 75 && hw > 0) begin
        c.slot_index = HND_W'($urandom_range(hw - 1));
        c.handle_generation = sb.gens[c.slot_index];
      end else if (pick < 85 && hw > 0) begin
        c.slot_index = HND_W'($urandom_range(hw - 1));
        c.handle_generation = sb.gens[c.slot_index] ^ GEN_W'($urandom_range(16'hFFFF, 1));
      end else if (pick < 92) begin
        c.slot_index = HND_W'(SLOTS);
      end
    end
    return c;
  endfunction

  // Called and returns at a falling edge; start stays up across back-to-back beats.
  task automatic send_cmd(input cmd_t c);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= c;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.apply_cmd(c);
    @(negedge clk_i);
  endtask

  task automatic run_phase(int unsigned n, int unsigned gap, int unsigned w_alloc,
                           int unsigned w_lookup, int unsigned w_destroy);
    idle_pct = gap;
    repeat (n) send_cmd(rand_cmd(w_alloc, w_lookup, w_destroy));
  endtask

  initial begin
    rst_ni   = 1'b0;
    start    = 1'b0;
    cmd_i    = '0;
    idle_pct = 0;
    sb = new();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty table: range, invalid marker, empty flush
    send_cmd(mk_cmd(CMD_LOOKUP, 0, 0, '0));
    send_cmd(mk_cmd(CMD_DESTROY, SLOTS, 0, '0));
    send_cmd(mk_cmd(CMD_DESTROY, 5, 0, '0));
    send_cmd(mk_cmd(CMD_FLUSH, 0, 0, '0));
    // grow the table with payload extremes, then good, stale and out-of-range handles
    send_cmd(mk_cmd(CMD_ALLOC, 2047, 16'hFFFF, 32'h0000_0000));
    send_cmd(mk_cmd(CMD_ALLOC, 0, 0, 32'hFFFF_FFFF));
    send_cmd(mk_cmd(CMD_ALLOC, 1023, 16'h5555, 32'hA5A5_5A5A));
    send_cmd(mk_cmd(CMD_LOOKUP, 0, 0, '0));
    send_cmd(mk_cmd(CMD_LOOKUP, 1, 0, '0));
    send_cmd(mk_cmd(CMD_LOOKUP, 1, 16'hFFFF, '0));
    send_cmd(mk_cmd(CMD_LOOKUP, 1023, 0, '0));
    send_cmd(mk_cmd(CMD_LOOKUP, SLOTS, 0, '0));
    send_cmd(mk_cmd(CMD_LOOKUP, 2047, 0, '0));
    send_cmd(mk_cmd(CMD_DESTROY, 1, 16'hFFFF, '0));
    send_cmd(mk_cmd(CMD_DESTROY, 2047, 0, '0));
    // duplicate destroy is queued, flush frees once
    send_cmd(mk_cmd(CMD_DESTROY, 1, 0, '0));
    send_cmd(mk_cmd(CMD_DESTROY, 1, 0, '0));
    send_cmd(mk_cmd(CMD_FLUSH, 0, 0, '0));
    // dead slot wins over generation check
    send_cmd(mk_cmd(CMD_LOOKUP, 1, 0, '0));
    send_cmd(mk_cmd(CMD_LOOKUP, 1, 1, '0));
    send_cmd(mk_cmd(CMD_DESTROY, 1, 1, '0));
    send_cmd(mk_cmd(CMD_FLUSH, 0, 0, '0));
    // reuse of the freed slot with its bumped generation
    send_cmd(mk_cmd(CMD_ALLOC, 0, 0, 32'h1234_5678));
    send_cmd(mk_cmd(CMD_LOOKUP, 1, 1, '0));
    send_cmd(mk_cmd(CMD_DESTROY, 0, 0, '0));

    run_phase(200, 0, 45, 25, 25);
    run_phase(250, 58, 25, 30, 35);
    // fill the table until no slot is left to allocate
    idle_pct = 7;
    while (!(sb.fill_cnt == SLOTS && sb.free_cnt == 0))
      send_cmd(rand_cmd(95, 5, 0));
    // rare flushes push the pending list to overflow
    run_phase(250, 7, 35, 15, 49);
    run_phase(100, 0, 30, 30, 30);

    start <= 1'b0;
    while (sb.due_rsp_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("%0d commands, %0d result beats checked, %0d errors",
             sb.n_cmds, sb.n_rsps, sb.errors);
    $display("ok %0d invalid %0d stale %0d dead %0d full %0d range %0d queue-full %0d",
             sb.status_seen[ST_OK], sb.status_seen[ST_INVALID],
             sb.status_seen[ST_STALE], sb.status_seen[ST_DEAD],
             sb.status_seen[ST_FULL], sb.status_seen[ST_RANGE],
             sb.status_seen[ST_QFULL]);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
